/* rtl/core/x64s_pkg.sv */
package x64s_pkg;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;
  localparam logic [63:0] STAR_MUL     = 64'h2545F4914F6CDD1D;

  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_RESEED  = 2'd0,
    OP_BOUNDED = 2'd1,
    OP_FRACT   = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  // which multiply just finished
  typedef enum logic [1:0] {
    PH_MIX_GAMMA = 2'd0,
    PH_MIX_A     = 2'd1,
    PH_MIX_B     = 2'd2,
    PH_STAR      = 2'd3
  } phase_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_POST = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_OUT  = 6'b010000,
    ST_SPARE = 6'b100000
  } fsm_t;

  function automatic logic [63:0] xorshift_step(input logic [63:0] s);
    logic [63:0] t;
    t = s ^ (s >> 12);
    t = t ^ (t << 25);
    t = t ^ (t >> 27);
    return t;
  endfunction

endpackage

/* rtl/core/xorshift64star_generator_core.sv */
// a reseed runs the gamma, mix A and mix B multiplies, a fraction draw the star
// multiply, a bounded draw with bound above 1 that multiply and the remainder loop,
// a small bound or unused opcode neither; one item at a time, via a 64-step radix-2
// remainder loop and a shared 32x32 multiplier (three passes per 64-bit product)
// reset (rst_n low, synchronous): seed cleared, generator state set to the golden gamma
module xorshift64star_generator_core
  import x64s_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic signed [63:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_stream_id,
  input  logic signed [31:0] in_bound,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_value
);

  fsm_t              fsm_r, fsm_nxt;
  phase_t            ph_r, ph_nxt;
  opcode_t           op_r, op_nxt;
  logic [63:0]       seed_r, seed_nxt;
  logic [63:0]       gen_state_r, gen_state_nxt;
  logic [63:0]       mul_a_r, mul_a_nxt;
  logic [63:0]       mul_b_r, mul_b_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [1:0]        mcnt_r, mcnt_nxt;
  logic [30:0]       bound_r, bound_nxt;
  logic [30:0]       rem_r, rem_nxt;
  logic [63:0]       dvd_r, dvd_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [63:0]       result_r, result_nxt;

  logic [31:0] inc32;
  logic [63:0] shuffled;
  logic [31:0] pa, pb;
  logic [63:0] prod;
  logic [63:0] z;
  logic [31:0] trial;
  logic        take;

  assign in_ready  = (fsm_r == ST_IDLE);
  assign out_valid = (fsm_r == ST_OUT);
  assign out_value = result_r;

  assign inc32    = $unsigned(in_stream_id) + 32'd1;
  assign shuffled = xorshift_step(gen_state_r);

  // shared 32x32 multiplier, partial products of the low 64 bits
  always_comb begin
    unique case (mcnt_r)
      2'd0:    begin pa = mul_a_r[31:0];  pb = mul_b_r[31:0];  end
      2'd1:    begin pa = mul_a_r[31:0];  pb = mul_b_r[63:32]; end
      default: begin pa = mul_a_r[63:32]; pb = mul_b_r[31:0];  end
    endcase
  end
  assign prod = {32'd0, pa} * {32'd0, pb};

  assign trial = {rem_r, dvd_r[63]};
  assign take  = (trial >= {1'b0, bound_r});

  always_comb begin
    fsm_nxt       = fsm_r;
    ph_nxt        = ph_r;
    op_nxt        = op_r;
    seed_nxt      = cfg_wr_en ? $unsigned(cfg_wr_data) : seed_r;
    gen_state_nxt = gen_state_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    acc_nxt       = acc_r;
    mcnt_nxt      = mcnt_r;
    bound_nxt     = bound_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    dcnt_nxt      = dcnt_r;
    result_nxt    = result_r;
    z             = '0;

    unique case (fsm_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = opcode_t'(in_opcode);
          bound_nxt  = in_bound[30:0];
          result_nxt = '0;
          mcnt_nxt   = 2'd0;
          priority if (opcode_t'(in_opcode) == OP_RESEED) begin
            mul_a_nxt = {{32{inc32[31]}}, inc32};
            mul_b_nxt = GOLDEN_GAMMA;
            ph_nxt    = PH_MIX_GAMMA;
            fsm_nxt   = ST_MUL;
          end else if ((opcode_t'(in_opcode) == OP_BOUNDED && in_bound > 32'sd1)
                       || opcode_t'(in_opcode) == OP_FRACT) begin
            gen_state_nxt = shuffled;
            mul_a_nxt     = shuffled;
            mul_b_nxt     = STAR_MUL;
            ph_nxt        = PH_STAR;
            fsm_nxt       = ST_MUL;
          end else begin
            fsm_nxt = ST_OUT;
          end
        end
      end
      ST_MUL: begin
        if (mcnt_r == 2'd0) begin
          acc_nxt = prod;
        end else begin
          acc_nxt = acc_r + {prod[31:0], 32'd0};
        end
        if (mcnt_r == 2'd2) begin
          fsm_nxt = ST_POST;
        end else begin
          mcnt_nxt = mcnt_r + 2'd1;
        end
      end
      ST_POST: begin
        mcnt_nxt = 2'd0;
        unique case (ph_r)
          PH_MIX_GAMMA: begin
            z         = seed_r ^ acc_r;
            mul_a_nxt = z ^ (z >> 30);
            mul_b_nxt = MIX_MUL_A;
            ph_nxt    = PH_MIX_A;
            fsm_nxt   = ST_MUL;
          end
          PH_MIX_A: begin
            mul_a_nxt = acc_r ^ (acc_r >> 27);
            mul_b_nxt = MIX_MUL_B;
            ph_nxt    = PH_MIX_B;
            fsm_nxt   = ST_MUL;
          end
          PH_MIX_B: begin
            z             = acc_r ^ (acc_r >> 31);
            gen_state_nxt = (z == 64'd0) ? GOLDEN_GAMMA : z;
            fsm_nxt       = ST_OUT;
          end
          default: begin
            if (op_r == OP_FRACT) begin
              result_nxt = acc_r >> 11;
              fsm_nxt    = ST_OUT;
            end else begin
              rem_nxt  = '0;
              dvd_nxt  = acc_r;
              dcnt_nxt = '0;
              fsm_nxt  = ST_DIV;
            end
          end
        endcase
      end
      ST_DIV: begin
        rem_nxt  = take ? 31'(trial - {1'b0, bound_r}) : trial[30:0];
        dvd_nxt  = {dvd_r[62:0], 1'b0};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          result_nxt = {33'd0, rem_nxt};
          fsm_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          fsm_nxt = ST_IDLE;
        end
      end
      default: begin
        fsm_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= ST_IDLE;
      seed_r      <= '0;
      gen_state_r <= GOLDEN_GAMMA;
    end else begin
      fsm_r       <= fsm_nxt;
      seed_r      <= seed_nxt;
      gen_state_r <= gen_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r     <= ph_nxt;
    op_r     <= op_nxt;
    mul_a_r  <= mul_a_nxt;
    mul_b_r  <= mul_b_nxt;
    acc_r    <= acc_nxt;
    mcnt_r   <= mcnt_nxt;
    bound_r  <= bound_nxt;
    rem_r    <= rem_nxt;
    dvd_r    <= dvd_nxt;
    dcnt_r   <= dcnt_nxt;
    result_r <= result_nxt;
  end

`ifndef SYNTHESIS
  a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    gen_state_r != 64'd0)
    else $error("generator state reached zero");

  a_rem_below_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fsm_r == ST_DIV |-> rem_r < bound_r)
    else $error("partial remainder not below bound");

  a_reseed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (op_r == OP_RESEED || op_r == OP_UNUSED) |-> out_value == 64'd0)
    else $error("reseed or unused opcode item with nonzero value");

  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("not ready for the next item after result taken");
`endif

endmodule

/* tb/xorshift64star_generator_checker.sv */
module xorshift64star_generator_checker
  import x64s_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_stream_id,
  input  logic [31:0] in_bound,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_value,
  output int          fail_count = 0,
  output int          outstanding = 0,
  output int          checked = 0
);

  localparam logic [63:0] GAMMA_K  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] FIN_K1   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] FIN_K2   = 64'h94D049BB133111EB;
  localparam logic [63:0] SCRAMBLE = 64'h2545F4914F6CDD1D;

  logic [63:0] seed_reg;
  logic [63:0] gen_state;
  logic [63:0] expected_values[$];
  int          fails = 0;
  int          n_checked = 0;

  function automatic logic [63:0] stream_state(input logic [63:0] base, input logic [31:0] id);
    logic [31:0] inc32;
    logic [63:0] inc64;
    logic [63:0] z;
    inc32 = id + 32'd1;
    inc64 = {{32{inc32[31]}}, inc32};
    z = base ^ (inc64 * GAMMA_K);
    z = z ^ (z >> 30);
    z = z * FIN_K1;
    z = z ^ (z >> 27);
    z = z * FIN_K2;
    z = z ^ (z >> 31);
    return (z == 64'd0) ? GAMMA_K : z;
  endfunction

  function automatic logic [63:0] shift_advance(input logic [63:0] s);
    logic [63:0] t;
    t = s ^ (s >> 12);
    t = t ^ (t << 25);
    t = t ^ (t >> 27);
    return t;
  endfunction

  function automatic logic [63:0] draw_value(input opcode_t op, input logic [31:0] id,
                                             input logic [31:0] bnd);
    logic [63:0] product;
    logic [63:0] value;
    value = 64'd0;
    case (op)
      OP_RESEED: begin
        gen_state = stream_state(seed_reg, id);
      end
      OP_BOUNDED: begin
        if (!bnd[31] && bnd > 32'd1) begin
          gen_state = shift_advance(gen_state);
          product = gen_state * SCRAMBLE;
          value = product % {32'd0, bnd};
        end
      end
      OP_FRACT: begin
        gen_state = shift_advance(gen_state);
        product = gen_state * SCRAMBLE;
        value = product >> 11;
      end
      default: begin
        value = 64'd0;
      end
    endcase
    return value;
  endfunction

  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst_n) begin
      seed_reg = 64'd0;
      gen_state = GAMMA_K;
      expected_values.delete();
    end else begin
      if (cfg_wr_en) begin
        seed_reg = cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          $error("value: unexpected item %h with nothing expected", out_value);
          fails++;
        end else begin
          want = expected_values.pop_front();
          n_checked++;
          if (out_value !== want) begin
            $error("value mismatch: expected %h, actual %h", want, out_value);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_values.insert(expected_values.size(),
                               draw_value(opcode_t'(in_opcode), in_stream_id, in_bound));
      end
    end
    fail_count <= fails;
    outstanding <= expected_values.size();
    checked <= n_checked;
  end

endmodule

/* tb/xorshift64star_generator_core_test.sv */
module xorshift64star_generator_core_test;
  import x64s_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic signed [63:0] cfg_wr_data = 64'sd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_opcode = OP_RESEED;
  logic signed [31:0] in_stream_id = 32'sd0;
  logic signed [31:0] in_bound = 32'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [63:0]        out_value;

  int fail_count;
  int outstanding;
  int checked;

  int burst_left = 0;
  int op_count[4] = '{0, 0, 0, 0};
  int seed_settings = 0;

  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;

  xorshift64star_generator_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_stream_id(in_stream_id),
    .in_bound    (in_bound),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value)
  );

  xorshift64star_generator_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_stream_id(in_stream_id),
    .in_bound    (in_bound),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver stall pattern: free, coin flip, mostly stalled, periodic
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 400);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= ((rx_tick % 5) < 2);
    endcase
  end

  task automatic send_item(input opcode_t op, input logic [31:0] id, input logic [31:0] bnd);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_stream_id <= id;
    in_bound <= bnd;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    op_count[op]++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    burst_left = 0;
  endtask

  task automatic set_seed(input logic [63:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seed_settings++;
  endtask

  task automatic random_item();
    int          pick;
    int          bsel;
    logic [31:0] id;
    logic [31:0] bnd;
    pick = $urandom_range(0, 99);
    bsel = $urandom_range(0, 9);
    id = $urandom;
    case ($urandom_range(0, 15))
      0: id = 32'h7FFFFFFF;
      1: id = 32'hFFFFFFFF;
      2: id = 32'h80000000;
      3: id = 32'h00000000;
      default: id = id;
    endcase
    case (bsel)
      0: bnd = $urandom_range(0, 1);
      1: bnd = {1'b1, 31'($urandom)};
      2: bnd = $urandom;
      3: bnd = $urandom_range(2, 16);
      4: bnd = 32'd1 << $urandom_range(1, 30);
      5: bnd = 32'h7FFFFFFF - $urandom_range(0, 1);
      6, 7: bnd = {1'b0, 31'($urandom)};
      default: bnd = $urandom_range(2, 1000);
    endcase
    if (pick < 15) begin
      send_item(OP_RESEED, id, bnd);
    end else if (pick < 60) begin
      send_item(OP_BOUNDED, id, bnd);
    end else if (pick < 93) begin
      send_item(OP_FRACT, id, bnd);
    end else begin
      send_item(OP_UNUSED, id, bnd);
    end
  endtask

  initial begin
    logic [63:0] phase_seed;
    logic [31:0] zero_id;
    logic [31:0] inc;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state, default seed
    send_item(OP_FRACT, 32'h0, 32'h0);
    send_item(OP_BOUNDED, 32'h0, 32'd2);
    send_item(OP_BOUNDED, 32'h0, 32'h7FFFFFFF);
    send_item(OP_BOUNDED, 32'h0, 32'd1);
    send_item(OP_BOUNDED, 32'h0, 32'd0);
    send_item(OP_BOUNDED, 32'h0, 32'hFFFFFFFF);
    send_item(OP_BOUNDED, 32'h0, 32'h80000000);
    send_item(OP_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF);
    // zero seed with id -1 gives a zero state, replaced by the gamma
    send_item(OP_RESEED, 32'hFFFFFFFF, 32'h0);
    send_item(OP_FRACT, 32'h0, 32'h0);
    send_item(OP_RESEED, 32'h7FFFFFFF, 32'h0);
    send_item(OP_BOUNDED, 32'hFFFFFFFF, 32'd3);
    send_item(OP_RESEED, 32'h80000000, 32'h7FFFFFFF);
    send_item(OP_FRACT, 32'h0, $urandom);

    set_seed(64'h7FFFFFFFFFFFFFFF);
    send_item(OP_RESEED, 32'h0, 32'h0);
    send_item(OP_FRACT, 32'h0, 32'h0);
    send_item(OP_BOUNDED, 32'h0, 32'h40000000);
    set_seed(64'h8000000000000000);
    send_item(OP_RESEED, 32'h7FFFFFFE, 32'h0);
    send_item(OP_BOUNDED, 32'h0, 32'h7FFFFFFF);
    set_seed(64'hFFFFFFFFFFFFFFFF);
    send_item(OP_RESEED, 32'hFFFFFFFF, 32'h0);
    send_item(OP_FRACT, 32'h0, 32'h0);
    send_item(OP_UNUSED, 32'h0, 32'h0);

    for (int phase = 0; phase < 8; phase++) begin
      zero_id = $urandom;
      case (phase)
        0: phase_seed = 64'h0;
        1: phase_seed = 64'h7FFFFFFFFFFFFFFF;
        2: phase_seed = 64'h8000000000000000;
        3: phase_seed = 64'hFFFFFFFFFFFFFFFF;
        6: begin
          inc = zero_id + 32'd1;
          phase_seed = {{32{inc[31]}}, inc} * GOLDEN_GAMMA;
        end
        default: phase_seed = {$urandom, $urandom};
      endcase
      set_seed(phase_seed);
      // seed chosen so that this reseed lands on a zero state
      if (phase == 6) begin
        send_item(OP_RESEED, zero_id, $urandom);
        send_item(OP_FRACT, $urandom, $urandom);
      end
      for (int k = 0; k < 210; k++) begin
        if ($urandom_range(0, 99) == 0) begin
          drain();
        end
        random_item();
      end
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("covered %0d reseeds, %0d bounded draws, %0d fraction draws, %0d unused opcodes",
             op_count[OP_RESEED], op_count[OP_BOUNDED], op_count[OP_FRACT],
             op_count[OP_UNUSED]);
    $display("over %0d seed settings, %0d results compared", seed_settings + 1, checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("status: fail");
    $finish;
  end

endmodule
